FILE: src/instrument_status_error_queue_unit_macros.svh
// assertion helpers for the status and error queue unit
`ifndef INSTRUMENT_STATUS_ERROR_QUEUE_UNIT_MACROS_SVH
`define INSTRUMENT_STATUS_ERROR_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define ISEQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: status queue check failed");

// next-cycle implication, checked on clk outside reset
`define ISEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: status queue check failed");

`endif

FILE: src/iseq_pkg.sv
package iseq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W       = 16;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_EVENT = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  // configuration register indexes
  localparam logic CFG_ESE = 1'b0;
  localparam logic CFG_SRE = 1'b1;

  // event status register bits
  localparam logic [7:0] ESR_OPC = 8'h01;
  localparam logic [7:0] ESR_RQC = 8'h02;
  localparam logic [7:0] ESR_QYE = 8'h04;
  localparam logic [7:0] ESR_DDE = 8'h08;
  localparam logic [7:0] ESR_EXE = 8'h10;
  localparam logic [7:0] ESR_CME = 8'h20;
  localparam logic [7:0] ESR_URQ = 8'h40;
  localparam logic [7:0] ESR_PON = 8'h80;

  // status byte bits
  localparam logic [7:0] STB_EAV = 8'h04;
  localparam logic [7:0] STB_QSB = 8'h08;
  localparam logic [7:0] STB_MAV = 8'h10;
  localparam logic [7:0] STB_ESB = 8'h20;
  localparam logic [7:0] STB_MSS = 8'h40;
  localparam logic [7:0] STB_OSB = 8'h80;

  localparam logic signed [NUM_W-1:0] OVERFLOW_NUMBER = -16'sd350;

  localparam logic signed [NUM_W-1:0] CLASS_EXE_TOP = -16'sd200;
  localparam logic signed [NUM_W-1:0] CLASS_DDE_TOP = -16'sd300;
  localparam logic signed [NUM_W-1:0] CLASS_QYE_TOP = -16'sd400;
  localparam logic signed [NUM_W-1:0] CLASS_PON_TOP = -16'sd500;
  localparam logic signed [NUM_W-1:0] CLASS_URQ_TOP = -16'sd600;
  localparam logic signed [NUM_W-1:0] CLASS_RQC_TOP = -16'sd700;
  localparam logic signed [NUM_W-1:0] CLASS_OPC_TOP = -16'sd800;
  localparam logic signed [NUM_W-1:0] CLASS_NONE_TOP = -16'sd900;

  // decoded command for one word
  typedef struct packed {
    logic push;
    logic pop;
    logic evt;
    logic clr;
  } dec_t;

  // esr bit latched by an error number
  function automatic logic [7:0] class_bit(input logic signed [NUM_W-1:0] n);
    logic [7:0] b;
    b = '0;
    if (n == '0)                b = '0;
    else if (n > 0)             b = ESR_DDE;
    else if (n > CLASS_EXE_TOP) b = ESR_CME;
    else if (n > CLASS_DDE_TOP) b = ESR_EXE;
    else if (n > CLASS_QYE_TOP) b = ESR_DDE;
    else if (n > CLASS_PON_TOP) b = ESR_QYE;
    else if (n > CLASS_URQ_TOP) b = ESR_PON;
    else if (n > CLASS_RQC_TOP) b = ESR_URQ;
    else if (n > CLASS_OPC_TOP) b = ESR_RQC;
    else if (n > CLASS_NONE_TOP) b = ESR_OPC;
    return b;
  endfunction

endpackage

FILE: src/instrument_status_error_queue_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    command, error_number, event_bits, summary_bits
// out      output     out_valid / out_ready  popped_valid, popped_number, status_byte,
//                                            event_status, queue_fill
// cfg      input      cfg_we                 cfg_index, cfg_data (ese, sre)
//
// one word per cycle while out_ready allows: an input register and a result
// register, with the queue pointer update, esr update and status byte worked
// out combinationally between them; a word waits until the result is free.
// reset clears queue pointers, fill count, esr, masks and both valid flags;
// the error store itself is not cleared.
// a stalled result holds the input register; a new word still enters while
// the input register drains into a free result register.
module instrument_status_error_queue_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [15:0] in_error_number,
  input  logic [7:0]         in_event_bits,
  input  logic [7:0]         in_summary_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_popped_valid,
  output logic signed [15:0] out_popped_number,
  output logic [7:0]         out_status_byte,
  output logic [7:0]         out_event_status,
  output logic [4:0]         out_queue_fill,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);

  logic               in_v_r, in_v_nxt;
  logic [2:0]         cmd_r;
  logic signed [15:0] num_r;
  logic [7:0]         ev_r;
  logic [7:0]         sum_r;
  logic               out_v_r, out_v_nxt;
  logic               pv_r;
  logic signed [15:0] pnum_r;
  logic [7:0]         stb_r;
  logic [7:0]         esr_out_r;
  logic [4:0]         fill_r;
  logic [7:0]         ese_r;
  logic [7:0]         sre_r;

  logic                              in_fire;
  logic                              proc_fire;
  iseq_pkg::dec_t                    dec;
  logic signed [iseq_pkg::NUM_W-1:0] head_data;
  logic                              q_not_empty;
  logic                              q_full;
  logic [iseq_pkg::CNT_W-1:0]        count_nxt;
  logic [7:0]                        esr_nxt;
  logic                              pv_nxt;
  logic signed [15:0]                pnum_nxt;
  logic [7:0]                        stb_nxt;

  assign proc_fire = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || proc_fire;
  assign in_fire   = in_valid && in_ready;
  assign in_v_nxt  = in_fire ? 1'b1 : (proc_fire ? 1'b0 : in_v_r);
  assign out_v_nxt = proc_fire ? 1'b1 : ((out_v_r && out_ready) ? 1'b0 : out_v_r);

  always_comb begin
    dec = '0;
    unique case (iseq_pkg::cmd_t'(cmd_r))
      iseq_pkg::CMD_PUSH:  dec.push = (num_r != '0);
      iseq_pkg::CMD_POP:   dec.pop  = 1'b1;
      iseq_pkg::CMD_EVENT: dec.evt  = 1'b1;
      iseq_pkg::CMD_CLEAR: dec.clr  = 1'b1;
      default:             dec      = '0;
    endcase
  end

  iseq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (proc_fire),
    .dec       (dec),
    .push_data (num_r),
    .head_data (head_data),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count_nxt (count_nxt)
  );

  iseq_event u_event (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (proc_fire),
    .dec        (dec),
    .number     (num_r),
    .ev_bits    (ev_r),
    .queue_full (q_full),
    .esr_nxt    (esr_nxt)
  );

  assign pv_nxt   = dec.pop && q_not_empty;
  assign pnum_nxt = pv_nxt ? head_data : '0;

  // status byte from the state after this word
  always_comb begin
    stb_nxt = sum_r & (iseq_pkg::STB_QSB | iseq_pkg::STB_MAV | iseq_pkg::STB_OSB);
    if (count_nxt != '0) stb_nxt = stb_nxt | iseq_pkg::STB_EAV;
    if ((esr_nxt & ese_r) != '0) stb_nxt = stb_nxt | iseq_pkg::STB_ESB;
    if ((stb_nxt & sre_r & ~iseq_pkg::STB_MSS) != '0) stb_nxt = stb_nxt | iseq_pkg::STB_MSS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      ese_r   <= '0;
      sre_r   <= '0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          iseq_pkg::CFG_ESE: ese_r <= cfg_data;
          iseq_pkg::CFG_SRE: sre_r <= cfg_data;
          default:           ese_r <= ese_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_command;
      num_r <= in_error_number;
      ev_r  <= in_event_bits;
      sum_r <= in_summary_bits;
    end
    if (proc_fire) begin
      pv_r      <= pv_nxt;
      pnum_r    <= pnum_nxt;
      stb_r     <= stb_nxt;
      esr_out_r <= esr_nxt;
      fill_r    <= 5'(count_nxt);
    end
  end

  assign out_valid         = out_v_r;
  assign out_popped_valid  = pv_r;
  assign out_popped_number = pnum_r;
  assign out_status_byte   = stb_r;
  assign out_event_status  = esr_out_r;
  assign out_queue_fill    = fill_r;

`include "instrument_status_error_queue_unit_macros.svh"

  `ISEQ_ASSERT_NOW(a_empty_pop_zero, out_valid && !out_popped_valid, out_popped_number == 16'sd0)
  `ISEQ_ASSERT_NOW(a_eav_tracks_fill, out_valid, out_status_byte[2] == (out_queue_fill != 5'd0))
  `ISEQ_ASSERT_NEXT(a_clear_empties, proc_fire && dec.clr, out_event_status == 8'd0 && out_queue_fill == 5'd0)

endmodule

FILE: src/iseq_queue.sv
module iseq_queue (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    fire,
  input  iseq_pkg::dec_t                          dec,
  input  logic signed [iseq_pkg::NUM_W-1:0]       push_data,
  output logic signed [iseq_pkg::NUM_W-1:0]       head_data,
  output logic                                    not_empty,
  output logic                                    full,
  output logic [iseq_pkg::CNT_W-1:0]              count_nxt
);

  logic signed [iseq_pkg::NUM_W-1:0] store [iseq_pkg::QUEUE_DEPTH];
  logic [iseq_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [iseq_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [iseq_pkg::CNT_W-1:0] count_r;
  logic [iseq_pkg::PTR_W-1:0] wr_prev;
  logic [iseq_pkg::PTR_W-1:0] rd_inc;
  logic [iseq_pkg::PTR_W-1:0] wr_inc;

  localparam logic [iseq_pkg::PTR_W-1:0] PTR_LAST =
    iseq_pkg::PTR_W'(iseq_pkg::QUEUE_DEPTH - 1);

  assign not_empty = (count_r != '0);
  assign full      = (count_r == iseq_pkg::CNT_W'(iseq_pkg::QUEUE_DEPTH));
  assign head_data = store[rd_ptr_r];

  assign rd_inc  = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc  = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign wr_prev = (wr_ptr_r == '0) ? PTR_LAST : wr_ptr_r - 1'b1;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (dec.clr) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      count_nxt  = '0;
    end else if (dec.push && !full) begin
      wr_ptr_nxt = wr_inc;
      count_nxt  = count_r + 1'b1;
    end else if (dec.pop && not_empty) begin
      rd_ptr_nxt = rd_inc;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else if (fire) begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // full queue: newest entry turns into the overflow marker
  always_ff @(posedge clk) begin
    if (fire && dec.push) begin
      if (full) store[wr_prev] <= iseq_pkg::OVERFLOW_NUMBER;
      else      store[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/iseq_event.sv
module iseq_event (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  iseq_pkg::dec_t                    dec,
  input  logic signed [iseq_pkg::NUM_W-1:0] number,
  input  logic [7:0]                        ev_bits,
  input  logic                              queue_full,
  output logic [7:0]                        esr_nxt
);

  logic [7:0] esr_r;

  always_comb begin
    esr_nxt = esr_r;
    if (dec.clr) begin
      esr_nxt = '0;
    end else if (dec.push) begin
      esr_nxt = esr_r | iseq_pkg::class_bit(number)
              | (queue_full ? iseq_pkg::ESR_DDE : 8'h00);
    end else if (dec.evt) begin
      esr_nxt = esr_r | ev_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esr_r <= '0;
    end else if (fire) begin
      esr_r <= esr_nxt;
    end
  end

endmodule

FILE: test/instrument_status_error_queue_unit_test.sv
`timescale 1ns / 100ps

module instrument_status_error_queue_unit_test;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  localparam int DIRECTED_ROWS   = 25;
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 250;
  localparam int QUIET_WORDS     = 200;
  localparam int MIX_BLOCK       = 32;
  localparam int LONG_HOLD       = 64;
  localparam int SETTLE_CYCLES   = 6;
  localparam int STALL_LIMIT     = 2000;

  typedef struct packed {
    logic               popped_valid;
    logic signed [15:0] popped_number;
    logic [7:0]         status_byte;
    logic [7:0]         event_status;
    logic [4:0]         queue_fill;
  } status_word_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] error_number;
    logic [7:0]         event_bits;
    logic [7:0]         summary_bits;
    logic               typed;
    status_word_t       typed_result;
  } command_row_t;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  localparam status_word_t ZERO_WORD = '0;
  localparam logic [7:0] SUMMARY_ALL = iseq_pkg::STB_OSB | iseq_pkg::STB_MAV
                                     | iseq_pkg::STB_QSB;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_command;
  logic signed [15:0] in_error_number;
  logic [7:0]         in_event_bits;
  logic [7:0]         in_summary_bits;
  logic               out_valid;
  logic               out_ready;
  logic               out_popped_valid;
  logic signed [15:0] out_popped_number;
  logic [7:0]         out_status_byte;
  logic [7:0]         out_event_status;
  logic [4:0]         out_queue_fill;
  logic               cfg_we;
  logic               cfg_index;
  logic [7:0]         cfg_data;

  instrument_status_error_queue_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_error_number  (in_error_number),
    .in_event_bits    (in_event_bits),
    .in_summary_bits  (in_summary_bits),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_valid (out_popped_valid),
    .out_popped_number(out_popped_number),
    .out_status_byte  (out_status_byte),
    .out_event_status (out_event_status),
    .out_queue_fill   (out_queue_fill),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // status model state
  logic signed [15:0] error_slots [iseq_pkg::QUEUE_DEPTH];
  int                 head_slot;
  int                 held_entries;
  logic [7:0]         esr_model;
  logic [7:0]         ese_model;
  logic [7:0]         sre_model;

  status_word_t       pending_words [$];
  command_row_t       directed_rows [DIRECTED_ROWS];

  int  mismatches;
  int  words_sent;
  int  results_checked;
  int  overflow_pushes;
  int  empty_pops;
  int  mss_results;
  int  mask_settings;
  bit  quiet_tail;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] esr_class_of(logic signed [15:0] n);
    int decade;
    if (n > 0) return iseq_pkg::ESR_DDE;
    if (n == 0) return '0;
    // classes go by hundreds below zero, -1..-199 all command errors
    decade = -int'(n) / 100;
    case (decade)
      0, 1:    return iseq_pkg::ESR_CME;
      2:       return iseq_pkg::ESR_EXE;
      3:       return iseq_pkg::ESR_DDE;
      4:       return iseq_pkg::ESR_QYE;
      5:       return iseq_pkg::ESR_PON;
      6:       return iseq_pkg::ESR_URQ;
      7:       return iseq_pkg::ESR_RQC;
      8:       return iseq_pkg::ESR_OPC;
      default: return '0;
    endcase
  endfunction

  function automatic status_word_t advance_status_model(logic [2:0] cmd,
                                                       logic signed [15:0] num,
                                                       logic [7:0] ev,
                                                       logic [7:0] summ);
    status_word_t w;
    logic [7:0]   stb;
    w = ZERO_WORD;
    case (cmd)
      iseq_pkg::CMD_PUSH: begin
        if (num != 0) begin
          esr_model |= esr_class_of(num);
          if (held_entries >= iseq_pkg::QUEUE_DEPTH) begin
            // full: newest held entry is replaced by the overflow number
            error_slots[(head_slot + held_entries - 1) % iseq_pkg::QUEUE_DEPTH] =
              iseq_pkg::OVERFLOW_NUMBER;
            esr_model |= iseq_pkg::ESR_DDE;
            overflow_pushes++;
          end else begin
            error_slots[(head_slot + held_entries) % iseq_pkg::QUEUE_DEPTH] = num;
            held_entries++;
          end
        end
      end
      iseq_pkg::CMD_POP: begin
        if (held_entries != 0) begin
          w.popped_valid  = 1'b1;
          w.popped_number = error_slots[head_slot];
          head_slot       = (head_slot + 1) % iseq_pkg::QUEUE_DEPTH;
          held_entries--;
        end else begin
          empty_pops++;
        end
      end
      iseq_pkg::CMD_EVENT: esr_model |= ev;
      iseq_pkg::CMD_CLEAR: begin
        esr_model    = '0;
        head_slot    = 0;
        held_entries = 0;
      end
      default: ;
    endcase
    stb = summ & SUMMARY_ALL;
    if (held_entries != 0) stb |= iseq_pkg::STB_EAV;
    if ((esr_model & ese_model) != 0) stb |= iseq_pkg::STB_ESB;
    if ((stb & sre_model & ~iseq_pkg::STB_MSS) != 0) stb |= iseq_pkg::STB_MSS;
    w.status_byte  = stb;
    w.event_status = esr_model;
    w.queue_fill   = 5'(held_entries);
    return w;
  endfunction

  function automatic logic signed [15:0] pick_error_number();
    int sel;
    int mag;
    logic signed [15:0] n;
    sel = $urandom_range(0, 19);
    case (sel)
      0: n = '0;
      1, 2: n = 16'($urandom);
      3, 4: n = 16'($urandom_range(1, 32767));
      5: begin
        mag = $urandom_range(900, 32768);
        n   = 16'(-mag);
      end
      6, 7: begin
        // either side of a class boundary
        mag = 100 * $urandom_range(1, 9) - $urandom_range(0, 1);
        n   = 16'(-mag);
      end
      default: begin
        mag = 100 * $urandom_range(0, 8) + $urandom_range(1, 99);
        n   = 16'(-mag);
      end
    endcase
    return n;
  endfunction

  function automatic logic [2:0] pick_command(traffic_mix_t mix);
    int r;
    int push_pct;
    int pop_pct;
    case (mix)
      MIX_FILL: begin
        push_pct = 75;
        pop_pct  = 10;
      end
      MIX_DRAIN: begin
        push_pct = 15;
        pop_pct  = 70;
      end
      default: begin
        push_pct = 40;
        pop_pct  = 35;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < push_pct) return iseq_pkg::CMD_PUSH;
    if (r < push_pct + pop_pct) return iseq_pkg::CMD_POP;
    r = $urandom_range(0, 99);
    if (r < 40) return iseq_pkg::CMD_EVENT;
    if (r < 75) return iseq_pkg::CMD_READ;
    if (r < 88) return iseq_pkg::CMD_CLEAR;
    return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  task automatic offer_word(input logic [2:0] cmd, input logic signed [15:0] num,
                            input logic [7:0] ev, input logic [7:0] summ,
                            output status_word_t predicted);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_error_number <= num;
    in_event_bits   <= ev;
    in_summary_bits <= summ;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_status_model(cmd, num, ev, summ);
    words_sent++;
  endtask

  task automatic sender_gap(input int pct);
    if (!quiet_tail && $urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_masks(input logic [7:0] ese, input logic [7:0] sre);
    cfg_we    <= 1'b1;
    cfg_index <= iseq_pkg::CFG_ESE;
    cfg_data  <= ese;
    @(posedge clk);
    cfg_index <= iseq_pkg::CFG_SRE;
    cfg_data  <= sre;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ese_model = ese;
    sre_model = sre;
    mask_settings++;
  endtask

  task automatic compare_word(input status_word_t want, input status_word_t got);
    if (got.popped_valid !== want.popped_valid) begin
      $error("popped_valid: expected %0d, got %0d", want.popped_valid, got.popped_valid);
      mismatches++;
    end
    if (got.popped_number !== want.popped_number) begin
      $error("popped_number: expected %0d, got %0d", want.popped_number, got.popped_number);
      mismatches++;
    end
    if (got.status_byte !== want.status_byte) begin
      $error("status_byte: expected %02h, got %02h", want.status_byte, got.status_byte);
      mismatches++;
    end
    if (got.event_status !== want.event_status) begin
      $error("event_status: expected %02h, got %02h", want.event_status, got.event_status);
      mismatches++;
    end
    if (got.queue_fill !== want.queue_fill) begin
      $error("queue_fill: expected %0d, got %0d", want.queue_fill, got.queue_fill);
      mismatches++;
    end
  endtask

  // result side: checks each word and paces out_ready
  initial begin
    int           stall_left;
    int           hold_left;
    int           idle_pct;
    logic         next_ready;
    status_word_t got;
    stall_left = 0;
    hold_left  = 0;
    idle_pct   = 8;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_popped_valid, out_popped_number, out_status_byte,
                out_event_status, out_queue_fill};
        if (pending_words.size() == 0) begin
          $error("result word arrived with nothing expected");
          mismatches++;
        end else begin
          compare_word(pending_words.pop_front(), got);
        end
        if (got.status_byte & iseq_pkg::STB_MSS) mss_results++;
        results_checked++;
        if (results_checked % 50 == 0) begin
          case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 8;
            default: idle_pct = 20;
          endcase
        end
        // long hold so the pipeline backs up into the input
        if (results_checked == 300 || results_checked == 900) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 8) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout after %0d cycles with no word moving", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    status_word_t predicted;
    traffic_mix_t mix;
    int           gap_pct;
    logic [7:0]   ese;
    logic [7:0]   sre;

    mismatches      = 0;
    words_sent      = 0;
    results_checked = 0;
    overflow_pushes = 0;
    empty_pops      = 0;
    mss_results     = 0;
    mask_settings   = 0;
    quiet_tail      = 1'b0;
    head_slot       = 0;
    held_entries    = 0;
    esr_model       = '0;
    ese_model       = '0;
    sre_model       = '0;
    mix             = MIX_EVEN;
    gap_pct         = 0;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= iseq_pkg::CMD_READ;
    in_error_number <= '0;
    in_event_bits   <= '0;
    in_summary_bits <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= iseq_pkg::CFG_ESE;
    cfg_data        <= '0;

    // masks stay at reset value through this part
    directed_rows = '{
      '{iseq_pkg::CMD_READ,  16'sd0,     8'h00, 8'h00, 1'b1, ZERO_WORD},
      '{iseq_pkg::CMD_POP,   16'sd0,     8'h00, 8'hFF, 1'b1,
        '{1'b0, 16'sd0, SUMMARY_ALL, 8'h00, 5'd0}},
      '{iseq_pkg::CMD_PUSH,  16'sd0,     8'hFF, 8'h00, 1'b1, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd100,   8'h00, 8'h00, 1'b1,
        '{1'b0, 16'sd0, iseq_pkg::STB_EAV, iseq_pkg::ESR_CME, 5'd1}},
      '{iseq_pkg::CMD_PUSH, -16'sd200,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd399,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd400,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd599,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd600,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd799,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd800,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd900,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH,  16'sh8000,  8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH,  16'sd32767, 8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH,  16'sd1,     8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd1,     8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd199,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd899,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH, -16'sd300,   8'h00, 8'h00, 1'b0, ZERO_WORD},
      '{iseq_pkg::CMD_PUSH,  16'sd12345, 8'h00, 8'h00, 1'b1,
        '{1'b0, 16'sd0, iseq_pkg::STB_EAV, 8'hFF, 5'd16}},
      '{iseq_pkg::CMD_POP,   16'sd0,     8'h00, 8'h00, 1'b1,
        '{1'b1, -16'sd100, iseq_pkg::STB_EAV, 8'hFF, 5'd15}},
      '{iseq_pkg::CMD_CLEAR, 16'sd0,     8'h00, 8'h00, 1'b1, ZERO_WORD},
      '{iseq_pkg::CMD_EVENT, 16'sd0,     8'h5A, 8'h00, 1'b1,
        '{1'b0, 16'sd0, 8'h00, 8'h5A, 5'd0}},
      '{CMD_SPARE_LAST,  16'sd0, 8'h00, 8'hFF, 1'b1,
        '{1'b0, 16'sd0, SUMMARY_ALL, 8'h5A, 5'd0}},
      '{CMD_SPARE_FIRST, 16'sd0, 8'h00, 8'h00, 1'b1,
        '{1'b0, 16'sd0, 8'h00, 8'h5A, 5'd0}}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].command, directed_rows[i].error_number,
                 directed_rows[i].event_bits, directed_rows[i].summary_bits, predicted);
      pending_words.push_back(directed_rows[i].typed ? directed_rows[i].typed_result
                                                     : predicted);
      sender_gap(15);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          ese = 8'hFF;
          sre = 8'hFF;
        end
        1: begin
          ese = 8'h00;
          sre = 8'hFF;
        end
        2: begin
          ese = 8'hFF;
          sre = 8'h00;
        end
        default: begin
          ese = 8'($urandom);
          sre = 8'($urandom);
        end
      endcase
      drain_results();
      write_masks(ese, sre);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (i % MIX_BLOCK == 0) begin
          mix = traffic_mix_t'($urandom_range(0, 2));
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 15;
            default: gap_pct = 35;
          endcase
        end
        if (phase == PHASES - 1 && i >= WORDS_PER_PHASE - QUIET_WORDS) quiet_tail = 1'b1;
        offer_word(pick_command(mix), pick_error_number(), 8'($urandom), 8'($urandom),
                   predicted);
        pending_words.push_back(predicted);
        sender_gap(gap_pct);
      end
    end

    drain_results();

    $display("%0d words sent, %0d results checked over %0d mask settings",
             words_sent, results_checked, mask_settings);
    $display("%0d overflow pushes, %0d pops on an empty queue, %0d results with MSS set",
             overflow_pushes, empty_pops, mss_results);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
